@@ sv/psg_pkg.sv @@
// ----------------------------------------------------------------------------
// psg_pkg
// Shared constants and the arctangent table of the phase-modulated sine
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

  localparam int PHASE_BITS_DEF    = 32;
  localparam int OUT_BITS_DEF      = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int ATAN_ENTRIES = 24;
  localparam int FREQ_W       = 32;
  localparam int TURN_W       = 32;
  localparam int CW           = 34;

  localparam logic [CW-1:0] GAIN_Q30 = 34'd652032874;

  function automatic logic [TURN_W-1:0] psg_atan(input int idx);
    logic [TURN_W-1:0] v;
    case (idx)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10680862;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/phase_modulated_sine_generator_unit.sv @@
// Pipeline: an accepted item passes a multiply stage, a phase fold stage,
//   one register per CORDIC rotation and the output register.
// Throughput: one item per cycle while in_stall_o is low; a two-entry output
//   register and skid stage keep the pipeline moving while one result waits.
// Reset: clears all valid bits and the frequency word to zero.
// ----------------------------------------------------------------------------
// phase_modulated_sine_generator_unit
// Sample index times frequency word plus a per-item offset, and a pipelined
// CORDIC that yields the sine of that phase as a signed fixed-point sample.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_modulated_sine_generator_unit #(
  parameter int PHASE_BITS    = psg_pkg::PHASE_BITS_DEF,
  parameter int OUT_BITS      = psg_pkg::OUT_BITS_DEF,
  parameter int CORDIC_STAGES = psg_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [psg_pkg::FREQ_W-1:0]     cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [31:0]                    sample_index_i,
  input  wire logic signed [31:0]             phase_offset_i,
  input  wire logic                           sample_valid_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [OUT_BITS-1:0]          sine_value_o,
  output logic                                noise_slot_o
);
  import psg_pkg::*;

  localparam int AW = (PHASE_BITS < TURN_W) ? PHASE_BITS : TURN_W;
  localparam int NS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int SH = 31 - OUT_BITS;
  localparam logic signed [CW-1:0] RND = CW'(1) <<< (SH - 1);
  localparam logic signed [CW-1:0] LIM = (CW'(1) <<< (OUT_BITS - 1)) - CW'(1);

  logic [FREQ_W-1:0] freq_q;
  logic              en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= '0;
    end else if (cfg_we_i) begin
      freq_q <= cfg_wdata_i;
    end
  end

  // Multiply stage
  logic          m_v_q;
  logic          m_ok_q;
  logic [AW-1:0] m_prod_q;
  logic [AW-1:0] m_off_q;
  logic [AW-1:0] f_a;
  logic [AW-1:0] off_a;

  assign f_a   = freq_q[31 -: AW];
  assign off_a = phase_offset_i[31 -: AW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_ok_q   <= sample_valid_i;
      m_prod_q <= sample_index_i[AW-1:0] * f_a;
      m_off_q  <= off_a;
    end
  end

  // Fold stage and CORDIC rotations
  logic [NS:0]                cv_q;
  logic [NS:0]                ok_q;
  logic signed [CW-1:0]       x_q [NS+1];
  logic signed [CW-1:0]       y_q [NS+1];
  logic signed [CW-1:0]       z_q [NS+1];
  logic [AW-1:0]              sum;
  logic [TURN_W-1:0]          p32;
  logic signed [CW-1:0]       z_d;

  assign sum = m_prod_q + m_off_q;
  assign p32 = TURN_W'(sum) << (TURN_W - AW);

  always_comb begin
    if (p32[31] ^ p32[30]) begin
      z_d = $signed(34'sh0_8000_0000 - {2'b00, p32});
    end else begin
      z_d = $signed({{2{p32[31]}}, p32});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q[0] <= m_ok_q;
      x_q[0]  <= $signed(GAIN_Q30);
      y_q[0]  <= '0;
      z_q[0]  <= z_d;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    localparam logic signed [CW-1:0] AT = $signed(CW'(psg_atan(i)));
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (en) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ok_q[i+1] <= ok_q[i];
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - AT;
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + AT;
        end
      end
    end
  end

  // Round, saturate and output with skid
  logic signed [CW-1:0]       yr;
  logic signed [CW-1:0]       r;
  logic signed [OUT_BITS-1:0] res;
  logic                       o_v_q;
  logic                       sk_v_q;
  logic signed [OUT_BITS-1:0] o_sine_q;
  logic signed [OUT_BITS-1:0] sk_sine_q;
  logic                       o_noise_q;
  logic                       sk_noise_q;

  assign yr = y_q[NS] + RND;
  assign r  = yr >>> SH;

  always_comb begin
    if (!ok_q[NS]) begin
      res = '0;
    end else if (r > LIM) begin
      res = OUT_BITS'(LIM);
    end else if (r < -LIM) begin
      res = OUT_BITS'(-LIM);
    end else begin
      res = OUT_BITS'(r);
    end
  end

  assign en = !sk_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q  <= 1'b0;
      sk_v_q <= 1'b0;
    end else if (!o_v_q || !out_stall_i) begin
      if (sk_v_q) begin
        o_v_q  <= 1'b1;
        sk_v_q <= 1'b0;
      end else begin
        o_v_q <= cv_q[NS];
      end
    end else if (cv_q[NS] && !sk_v_q) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!o_v_q || !out_stall_i) begin
      if (sk_v_q) begin
        o_sine_q  <= sk_sine_q;
        o_noise_q <= sk_noise_q;
      end else begin
        o_sine_q  <= res;
        o_noise_q <= !ok_q[NS];
      end
    end else if (cv_q[NS] && !sk_v_q) begin
      sk_sine_q  <= res;
      sk_noise_q <= !ok_q[NS];
    end
  end

  assign in_stall_o   = sk_v_q;
  assign out_valid_o  = o_v_q;
  assign sine_value_o = o_sine_q;
  assign noise_slot_o = o_noise_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> o_v_q)
    else $error("skid holds an item while the output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q && !out_stall_i |=> !sk_v_q)
    else $error("skid did not drain after the output was taken");

  a_noise_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q && o_noise_q |-> o_sine_q == '0)
    else $error("invalid sample produced a nonzero sine");

  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q |-> o_sine_q != {1'b1, {(OUT_BITS-1){1'b0}}})
    else $error("sine output escaped saturation");

endmodule

`default_nettype wire

@@ bench/phase_modulated_sine_generator_unit_test.sv @@
// ----------------------------------------------------------------------------
// phase_modulated_sine_generator_unit_test
// Self-checking bench for the phase-modulated sine generator. It drives sample
// items under random sender and receiver idling, predicts each CORDIC sine
// sample in the bench, and compares every result in order with its prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_modulated_sine_generator_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUT_W      = psg_pkg::OUT_BITS_DEF;
  localparam int STAGES     = psg_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY    = STAGES + 2;
  localparam int HOLD_CYCLES = 300;
  localparam longint SINE_LIMIT = (64'sd1 <<< (OUT_W - 1)) - 1;

  typedef struct {
    logic signed [OUT_W-1:0] sine;
    logic                    noise;
  } sine_sample_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        cfg_we_i       = 1'b0;
  logic [psg_pkg::FREQ_W-1:0]  cfg_wdata_i    = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_stall_o;
  logic [31:0]                 sample_index_i = '0;
  logic signed [31:0]          phase_offset_i = '0;
  logic                        sample_valid_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i    = 1'b0;
  logic signed [OUT_W-1:0]     sine_value_o;
  logic                        noise_slot_o;

  longint atan_step [16] = '{
    536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10680862, 5340245,
    2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  sine_sample_t pending_samples[$];
  sine_sample_t head;
  logic [31:0]  freq_word_copy  = '0;
  logic [31:0]  stream_index    = '0;
  int           sender_idle_pct = 0;
  int           recv_idle_pct   = 0;
  logic         hold_req        = 1'b0;
  int           hold_left       = 0;
  int           error_count     = 0;
  int           items_sent      = 0;
  int           results_checked = 0;
  int           freq_settings   = 0;

  phase_modulated_sine_generator_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_index_i (sample_index_i),
    .phase_offset_i (phase_offset_i),
    .sample_valid_i (sample_valid_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sine_value_o   (sine_value_o),
    .noise_slot_o   (noise_slot_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [OUT_W-1:0] cordic_sine_of_turn(input logic [31:0] turn);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint r;
    x = 64'sd652032874;
    y = 0;
    case (turn[31:30])
      2'd1, 2'd2: z = 64'sd2147483648 - longint'({32'd0, turn});
      2'd0:       z = longint'({32'd0, turn});
      default:    z = longint'({32'd0, turn}) - 64'sd4294967296;
    endcase
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step[i];
      end
    end
    r = (y + (64'sd1 <<< (31 - OUT_W - 1))) >>> (31 - OUT_W);
    if (r > SINE_LIMIT) r = SINE_LIMIT;
    if (r < -SINE_LIMIT) r = -SINE_LIMIT;
    return r[OUT_W-1:0];
  endfunction

  function automatic sine_sample_t predict_sine(input logic [31:0] idx, input logic [31:0] off,
                                                input logic valid);
    sine_sample_t s;
    logic [31:0]  turn;
    if (!valid) begin
      s.sine  = '0;
      s.noise = 1'b1;
    end else begin
      turn    = idx * freq_word_copy + off;
      s.sine  = cordic_sine_of_turn(turn);
      s.noise = 1'b0;
    end
    return s;
  endfunction

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_samples.size() == 0) begin
          $error("unexpected result: sine_value %0d noise_slot %0b", sine_value_o, noise_slot_o);
          error_count++;
        end else begin
          head = pending_samples.pop_front();
          results_checked++;
          if (sine_value_o !== head.sine) begin
            $error("sine_value: expected %0d, got %0d", head.sine, sine_value_o);
            error_count++;
          end
          if (noise_slot_o !== head.noise) begin
            $error("noise_slot: expected %0b, got %0b", head.noise, noise_slot_o);
            error_count++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [31:0] idx, input logic [31:0] off, input logic valid);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_index_i <= idx;
    phase_offset_i <= off;
    sample_valid_i <= valid;
    do @(posedge clk_i); while (in_stall_o);
    pending_samples.insert(pending_samples.size(), predict_sine(idx, off, valid));
    items_sent++;
  endtask

  task automatic send_stream_item();
    logic [31:0] off;
    logic        valid;
    if ($urandom_range(99) < 20) stream_index = $urandom;
    else stream_index = stream_index + 1;
    off   = ($urandom_range(99) < 30) ? $urandom : 32'($signed($urandom_range(4095)) - 2048);
    valid = ($urandom_range(99) < 85);
    send_item(stream_index, off, valid);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_freq(input logic [31:0] word);
    wait_results_done();
    repeat (LATENCY) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    freq_word_copy = word;
    freq_settings++;
  endtask

  task automatic test_directed_extremes();
    logic [31:0] edge_offsets [10] = '{
      32'h0000_0000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000, 32'h3FFF_FFFF,
      32'h4000_0001, 32'hBFFF_FFFF, 32'hC000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF
    };
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    write_freq(32'h0000_0000);
    foreach (edge_offsets[i]) send_item(32'h0, edge_offsets[i], 1'b1);
    send_item(32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
    send_item(32'h0, 32'h0, 1'b0);
    write_freq(32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'h0, 1'b1);
    send_item(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_item(32'h1, 32'h8000_0000, 1'b1);
    send_item(32'h0, 32'h4000_0000, 1'b1);
    write_freq(32'h8000_0000);
    send_item(32'h1, 32'h0, 1'b1);
    send_item(32'h2, 32'h0, 1'b1);
    send_item(32'hFFFF_FFFF, 32'hC000_0000, 1'b1);
    send_item(32'h3, 32'h4000_0000, 1'b1);
    write_freq(32'h0000_0001);
    send_item(32'h4000_0000, 32'h0, 1'b1);
    send_item(32'hFFFF_FFFF, 32'h1, 1'b1);
  endtask

  task automatic test_stream_rates();
    int send_pct [3] = '{12, 68, 0};
    int recv_pct [3] = '{68, 12, 0};
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 2; k++) begin
        write_freq(k == 0 ? 32'($urandom_range(1 << 26)) : $urandom);
        sender_idle_pct = send_pct[r];
        recv_idle_pct   = recv_pct[r];
        repeat (200) send_stream_item();
      end
    end
  endtask

  task automatic test_output_backpressure();
    write_freq(32'h0123_4567);
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    hold_req <= 1'b1;
    repeat (120) send_stream_item();
  endtask

  task automatic test_sender_pause();
    write_freq(32'h8000_0000);
    sender_idle_pct = 12;
    recv_idle_pct   = 12;
    repeat (40) send_stream_item();
    wait_results_done();
    repeat (40) send_stream_item();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_stream_rates();
    test_output_backpressure();
    test_sender_pause();
    wait_results_done();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (pending_samples.size() != 0) begin
      $error("%0d expected results never arrived", pending_samples.size());
      error_count++;
    end
    $display("Checked %0d sine results from %0d items across %0d frequency words,",
             results_checked, items_sent, freq_settings);
    $display("with idling on both sides, a long output hold and a full drain pause.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
